// ===== rtl/core/dlte_pkg.sv =====
// shared types, constants and fixed-point helpers for the dense layer training engine
`default_nettype none
package dlte_pkg;

  localparam int MAX_INPUTS  = 16;
  localparam int MAX_OUTPUTS = 16;
  localparam int IDX_W       = 4;
  localparam int CNT_W       = 5;
  localparam int SH_W        = 20;

  localparam logic [2:0] KIND_WR_WEIGHT = 3'd0;
  localparam logic [2:0] KIND_WR_BIAS   = 3'd1;
  localparam logic [2:0] KIND_FWD       = 3'd2;
  localparam logic [2:0] KIND_GRAD_OUT  = 3'd3;
  localparam logic [2:0] KIND_BWD       = 3'd4;
  localparam logic [2:0] KIND_UPDATE    = 3'd5;
  localparam logic [2:0] KIND_CLEAR     = 3'd6;

  localparam logic [1:0] REG_INPUT_COUNT  = 2'd0;
  localparam logic [1:0] REG_OUTPUT_COUNT = 2'd1;
  localparam logic [1:0] REG_LEARN_RATE   = 2'd2;

  typedef enum logic [3:0] {
    OP_NOP, OP_WR_W, OP_WR_B, OP_FWD_MUL, OP_FWD_ACC, OP_FWD_LOAD, OP_GRAD,
    OP_BWD_MUL1, OP_BWD_MUL2, OP_BWD_APPLY, OP_UPD_MUL, OP_UPD_APPLY,
    OP_UPD_BMUL, OP_UPD_BAPPLY, OP_CLEAR, OP_SHIFT
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic signed [15:0] value;
    logic [15:0]        lr;
  } cmd_t;

  function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
    if (v > 36'sd32767) return 16'sh7fff;
    if (v < -36'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) return 32'sh7fffffff;
    if (v < -36'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [35:0] rnd12(input logic signed [32:0] p);
    logic signed [35:0] t;
    t = {{3{p[32]}}, p} + 36'sd2048;
    return t >>> 12;
  endfunction

  function automatic logic signed [35:0] rnd16(input logic signed [32:0] p);
    logic signed [35:0] t;
    t = {{3{p[32]}}, p} + 36'sd32768;
    return t >>> 16;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/dlte_cell.sv =====
// one output-neuron cell: weight column, bias, gradients, accumulator and shift tap
`default_nettype none
module dlte_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [dlte_pkg::IDX_W-1:0]  cell_idx,
  input  logic [dlte_pkg::CNT_W-1:0]  n_out,
  input  dlte_pkg::cmd_t              cmd,
  input  logic signed [dlte_pkg::SH_W-1:0] sh_in,
  output logic signed [dlte_pkg::SH_W-1:0] sh_out
);
  import dlte_pkg::*;

  logic signed [15:0] w  [MAX_INPUTS];
  logic signed [15:0] wg [MAX_INPUTS];
  logic signed [15:0] b, bg, og;
  logic signed [31:0] acc;
  logic signed [32:0] prod;
  logic signed [SH_W-1:0] sh;
  logic signed [16:0] ma;
  logic signed [15:0] mb;
  logic signed [35:0] rp12, rp16;
  logic active, hit;
  logic signed [15:0] w_row, wg_row;

  assign active = {1'b0, cell_idx} < n_out;
  assign hit    = cmd.col == cell_idx;
  assign w_row  = w[cmd.row];
  assign wg_row = wg[cmd.row];
  assign rp12   = rnd12(prod);
  assign rp16   = rnd16(prod);
  assign sh_out = sh;

  always_comb begin
    ma = {cmd.value[15], cmd.value};
    mb = w_row;
    case (cmd.op)
      OP_BWD_MUL1: begin
        ma = {og[15], og};
        mb = w_row;
      end
      OP_BWD_MUL2: begin
        ma = {cmd.value[15], cmd.value};
        mb = og;
      end
      OP_UPD_MUL: begin
        ma = {1'b0, cmd.lr};
        mb = wg_row;
      end
      OP_UPD_BMUL: begin
        ma = {1'b0, cmd.lr};
        mb = bg;
      end
      default: begin
        ma = {cmd.value[15], cmd.value};
        mb = w_row;
      end
    endcase
  end

  // gradients and accumulator reset to zero
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_INPUTS; i++) wg[i] <= '0;
      bg  <= '0;
      acc <= '0;
    end else begin
      case (cmd.op)
        OP_FWD_ACC:   if (active) acc <= sat32({{4{acc[31]}}, acc} + rp12);
        OP_FWD_LOAD:  acc <= '0;
        OP_GRAD:      if (active && hit) bg <= sat16({{20{bg[15]}}, bg}
                                               + {{20{cmd.value[15]}}, cmd.value});
        OP_BWD_APPLY: if (active) wg[cmd.row] <= sat16({{20{wg_row[15]}}, wg_row} + rp12);
        OP_CLEAR: begin
          for (int i = 0; i < MAX_INPUTS; i++) wg[i] <= '0;
          bg <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    case (cmd.op)
      OP_WR_W:       if (hit) w[cmd.row] <= cmd.value;
      OP_WR_B:       if (hit) b <= cmd.value;
      OP_GRAD:       if (active && hit) og <= cmd.value;
      OP_FWD_LOAD: begin
        if (active) sh <= SH_W'(sat16({{4{acc[31]}}, acc} + {{20{b[15]}}, b}));
        else sh <= '0;
      end
      OP_BWD_MUL2:   sh <= active ? rp12[SH_W-1:0] : '0;
      OP_UPD_APPLY:  if (active) w[cmd.row] <= sat16({{20{w_row[15]}}, w_row} - rp16);
      OP_UPD_BAPPLY: if (active) b <= sat16({{20{b[15]}}, b} - rp16);
      OP_SHIFT:      sh <= sh_in;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/dense_layer_train_engine_top.sv =====
// top level of the dense layer training engine: sequencer, output word register, cell chain
//
// usage:
//   input words arrive on s_tvalid/s_tready; kind in s_tuser, row, column and
//   value in s_tdata, last in s_tlast. results leave on m_tvalid/m_tready with
//   source in m_tuser, index and value in m_tdata, last of run in m_tlast.
//   registers (input count, output count, learning rate) are written on the
//   cfg channel; the user must write them only while the block is idle, which
//   the block itself does not enforce. cfg_ready is always high.
// sequence:
//   one word is worked on at a time; s_tready is high only when idle.
//   writes, output gradient and clear act in the exec state. a forward
//   element multiplies and accumulates; the last one adds bias and drains one
//   result per output. a backward element multiplies twice, applies, shifts
//   the chain of 16 cells through cell 0 into the sum and emits it. update
//   multiplies and applies each input row in use, then the bias.
// reset: rst clears gradients, accumulators, counts to 16 and rate to 655.
//   weights, bias and stored output gradients hold garbage until written.
// stall: a result sits in the output register until taken; the chain waits.
`default_nettype none
module dense_layer_train_engine_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // row_index[3:0], col_index[7:4], value[23:8]
  input  logic [2:0]  s_tuser,   // kind[2:0]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // out_index[3:0], out_value[19:4], zero[23:20]
  output logic [0:0]  m_tuser,   // source[0]
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import dlte_pkg::*;

  typedef enum logic [12:0] {
    ST_IDLE    = 13'b0000000000001,
    ST_EXEC    = 13'b0000000000010,
    ST_FACC    = 13'b0000000000100,
    ST_FLOAD   = 13'b0000000001000,
    ST_DRAIN   = 13'b0000000010000,
    ST_BMUL2   = 13'b0000000100000,
    ST_BAPPLY  = 13'b0000001000000,
    ST_BSUM    = 13'b0000010000000,
    ST_BEMIT   = 13'b0000100000000,
    ST_UMUL    = 13'b0001000000000,
    ST_UAPPLY  = 13'b0010000000000,
    ST_UBMUL   = 13'b0100000000000,
    ST_UBAPPLY = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic [CNT_W-1:0] in_cnt_reg, out_cnt_reg;
  logic [15:0]      lr;
  logic [CNT_W-1:0] n_in, n_out;

  // latched input word
  logic [2:0]         kind_q;
  logic [IDX_W-1:0]   row_q, col_q;
  logic signed [15:0] val_q;
  logic               last_q;

  logic [IDX_W-1:0]   cnt, ucnt;
  logic signed [23:0] sum;
  logic               row_ok;

  // output word register
  logic               o_valid, out_free, out_load;
  logic               o_src, o_last, ld_src, ld_last;
  logic [IDX_W-1:0]   o_idx, ld_idx;
  logic signed [15:0] o_val, ld_val;

  cmd_t cmd;
  logic signed [SH_W-1:0] sh [MAX_OUTPUTS+1];

  assign cfg_ready = 1'b1;
  assign s_tready  = state == ST_IDLE;
  assign out_free  = !o_valid || m_tready;
  assign m_tvalid  = o_valid;
  assign m_tdata   = {4'd0, o_val, o_idx};
  assign m_tuser   = o_src;
  assign m_tlast   = o_last;

  // counts in use are clamped to 1..16
  assign n_in  = (in_cnt_reg == '0) ? CNT_W'(1) :
                 (in_cnt_reg > CNT_W'(MAX_INPUTS)) ? CNT_W'(MAX_INPUTS) : in_cnt_reg;
  assign n_out = (out_cnt_reg == '0) ? CNT_W'(1) :
                 (out_cnt_reg > CNT_W'(MAX_OUTPUTS)) ? CNT_W'(MAX_OUTPUTS) : out_cnt_reg;
  assign row_ok = {1'b0, row_q} < n_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_cnt_reg  <= CNT_W'(16);
      out_cnt_reg <= CNT_W'(16);
      lr          <= 16'd655;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_INPUT_COUNT:  in_cnt_reg  <= cfg_data[CNT_W-1:0];
        REG_OUTPUT_COUNT: out_cnt_reg <= cfg_data[CNT_W-1:0];
        REG_LEARN_RATE:   lr          <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer: next state, cell command and output load
  always_comb begin
    state_next = state;
    cmd.op     = OP_NOP;
    cmd.row    = row_q;
    cmd.col    = col_q;
    cmd.value  = val_q;
    cmd.lr     = lr;
    out_load   = 1'b0;
    ld_src     = 1'b0;
    ld_idx     = cnt;
    ld_val     = sh[0][15:0];
    ld_last    = {1'b0, cnt} == n_out - CNT_W'(1);
    case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_EXEC;
      ST_EXEC: begin
        state_next = ST_IDLE;
        case (kind_q)
          KIND_WR_WEIGHT: cmd.op = OP_WR_W;
          KIND_WR_BIAS:   cmd.op = OP_WR_B;
          KIND_GRAD_OUT:  cmd.op = OP_GRAD;
          KIND_CLEAR:     cmd.op = OP_CLEAR;
          KIND_FWD: begin
            if (row_ok) begin
              cmd.op     = OP_FWD_MUL;
              state_next = ST_FACC;
            end else if (last_q) begin
              state_next = ST_FLOAD;
            end
          end
          KIND_BWD: begin
            if (row_ok) begin
              cmd.op     = OP_BWD_MUL1;
              state_next = ST_BMUL2;
            end
          end
          KIND_UPDATE: begin
            cmd.op     = OP_UPD_MUL;
            cmd.row    = ucnt;
            state_next = ST_UAPPLY;
          end
          default: ;
        endcase
      end
      ST_FACC: begin
        cmd.op     = OP_FWD_ACC;
        state_next = last_q ? ST_FLOAD : ST_IDLE;
      end
      ST_FLOAD: begin
        cmd.op     = OP_FWD_LOAD;
        state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (out_free) begin
          out_load = 1'b1;
          cmd.op   = OP_SHIFT;
          if (ld_last) state_next = ST_IDLE;
        end
      end
      ST_BMUL2: begin
        cmd.op     = OP_BWD_MUL2;
        state_next = ST_BAPPLY;
      end
      ST_BAPPLY: begin
        cmd.op     = OP_BWD_APPLY;
        state_next = ST_BSUM;
      end
      ST_BSUM: begin
        cmd.op = OP_SHIFT;
        if (cnt == IDX_W'(MAX_OUTPUTS - 1)) state_next = ST_BEMIT;
      end
      ST_BEMIT: begin
        ld_src  = 1'b1;
        ld_idx  = row_q;
        ld_val  = sat16(36'(sum));
        ld_last = 1'b1;
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_UMUL: begin
        cmd.op     = OP_UPD_MUL;
        cmd.row    = ucnt;
        state_next = ST_UAPPLY;
      end
      ST_UAPPLY: begin
        cmd.op     = OP_UPD_APPLY;
        cmd.row    = ucnt;
        state_next = ({1'b0, ucnt} == n_in - CNT_W'(1)) ? ST_UBMUL : ST_UMUL;
      end
      ST_UBMUL: begin
        cmd.op     = OP_UPD_BMUL;
        state_next = ST_UBAPPLY;
      end
      ST_UBAPPLY: begin
        cmd.op     = OP_UPD_BAPPLY;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      o_valid <= 1'b0;
      cnt     <= '0;
      ucnt    <= '0;
    end else begin
      state <= state_next;
      if (out_load) o_valid <= 1'b1;
      else if (m_tready) o_valid <= 1'b0;
      case (state)
        ST_IDLE:   ucnt <= '0;
        ST_FLOAD:  cnt  <= '0;
        ST_BAPPLY: cnt  <= '0;
        ST_DRAIN:  if (out_free) cnt <= cnt + IDX_W'(1);
        ST_BSUM:   cnt  <= cnt + IDX_W'(1);
        ST_UAPPLY: ucnt <= ucnt + IDX_W'(1);
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      kind_q <= s_tuser;
      row_q  <= s_tdata[3:0];
      col_q  <= s_tdata[7:4];
      val_q  <= s_tdata[23:8];
      last_q <= s_tlast;
    end
    if (state == ST_BAPPLY) sum <= '0;
    else if (state == ST_BSUM) sum <= sum + {{(24-SH_W){sh[0][SH_W-1]}}, sh[0]};
    if (out_load) begin
      o_src  <= ld_src;
      o_idx  <= ld_idx;
      o_val  <= ld_val;
      o_last <= ld_last;
    end
  end

  // cell chain, values shift toward cell 0
  assign sh[MAX_OUTPUTS] = '0;
  for (genvar j = 0; j < MAX_OUTPUTS; j++) begin : g_cell
    dlte_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (IDX_W'(j)),
      .n_out    (n_out),
      .cmd      (cmd),
      .sh_in    (sh[j+1]),
      .sh_out   (sh[j])
    );
  end

  // checks
  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    o_valid && !m_tready |-> !out_load)
    else $error("output word overwritten while stalled");
  a_emit_after_sum: assert property (@(posedge clk) disable iff (rst)
    state == ST_BEMIT |-> $past(state) == ST_BSUM || $past(state) == ST_BEMIT)
    else $error("input gradient emitted without full chain sum");
  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAIN || state == ST_BSUM |-> !s_tready)
    else $error("input taken while results pending");

endmodule
`default_nettype wire
